// ===== rtl/mtfm_pkg.sv =====
// Shared types and constants for the topic filter matcher.
// No dependencies; every other file but mtfm_if.sv imports this package.
package mtfm_pkg;

   // Request function codes.
   localparam logic [1:0] FN_FILTER = 2'd0;
   localparam logic [1:0] FN_TOPIC  = 2'd1;
   localparam logic [1:0] FN_EVAL   = 2'd2;

   // Response status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_INVAL = 2'd1;
   localparam logic [1:0] ST_OVER  = 2'd2;

   // Characters with a meaning in filters and topics.
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SLASH  = 8'h2F;

   // Result of one evaluation, handed from the walker to the top level.
   typedef struct packed {
      logic       valid;
      logic [1:0] status;
      logic       match;
   } result_type;

   // True for either wildcard character.
   function automatic logic is_wild(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_HASH);
   endfunction

endpackage

// ===== rtl/mtfm_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on nothing; used by the top level and the testbench.
interface mtfm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface mtfm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic       match;

   modport source (output valid, output status, output match, input ready);
   modport sink   (input valid, input status, input match, output ready);
endinterface

// ===== rtl/mqtt_topic_filter_match.sv =====
// Topic filter matcher: an append word stores one character of the filter or
// the topic (NUL is dropped, a character past MAX_LEN marks overflow). An
// evaluate word ends straight from the idle state when the buffers overflowed
// or one is empty. Otherwise the sequencer loads its window, checks a leading
// '$' and walks. The sequencer moves each buffer pointer by at most one
// character a step through the single read port of each buffer. Ready stays
// low while an evaluate word is in progress. The response word carries the
// status and the match flag. Both buffers and the overflow mark are cleared
// as it is produced.
module mqtt_topic_filter_match
   import mtfm_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic              clock,
   input  logic              reset,
   mtfm_req_if.sink          req_ch,
   mtfm_rsp_if.source        rsp_ch
);
   localparam int LW = $clog2(MAX_LEN+1);
   localparam int CW = $clog2(MAX_LEN+4);

   logic          acc, nz, f_wr, t_wr, start, busy;
   logic          f_full, t_full;
   logic [LW-1:0] f_len, t_len;
   logic [CW-1:0] f_addr, t_addr;
   logic [7:0]    f_rd, t_rd;
   result_type    result;
   logic          ovf_ff, ovf_in;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic          rsp_match_ff;

   // Request acceptance and decode.
   assign req_ch.ready = !busy && (!rsp_valid_ff || rsp_ch.ready);
   assign acc   = req_ch.valid && req_ch.ready;
   assign nz    = (req_ch.data_byte != CH_NUL);
   assign f_wr  = acc && nz && (req_ch.func == FN_FILTER);
   assign t_wr  = acc && nz && (req_ch.func == FN_TOPIC);
   assign start = acc && (req_ch.func == FN_EVAL);

   mtfm_buf #(.MAX_LEN(MAX_LEN)) u_fbuf (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (f_wr),
      .wr_data (req_ch.data_byte),
      .clear   (result.valid),
      .full    (f_full),
      .len     (f_len),
      .rd_addr (f_addr),
      .rd_data (f_rd)
   );

   mtfm_buf #(.MAX_LEN(MAX_LEN)) u_tbuf (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (t_wr),
      .wr_data (req_ch.data_byte),
      .clear   (result.valid),
      .full    (t_full),
      .len     (t_len),
      .rd_addr (t_addr),
      .rd_data (t_rd)
   );

   mtfm_walk #(.MAX_LEN(MAX_LEN)) u_walk (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .ovf    (ovf_ff),
      .f_len  (f_len),
      .t_len  (t_len),
      .f_addr (f_addr),
      .t_addr (t_addr),
      .f_rd   (f_rd),
      .t_rd   (t_rd),
      .busy   (busy),
      .result (result)
   );

   // Overflow mark: set by a character that finds its buffer full.
   always_comb begin
      ovf_in = ovf_ff;
      if (result.valid) begin
         ovf_in = 1'b0;
      end else if ((f_wr && f_full) || (t_wr && t_full)) begin
         ovf_in = 1'b1;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ovf_ff <= ovf_in;
         if (result.valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (result.valid) begin
         rsp_status_ff <= result.status;
         rsp_match_ff  <= result.match;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.match  = rsp_match_ff;

endmodule

// ===== rtl/mtfm_buf.sv =====
// Character buffer: one memory with a fill count and a registered read port.
// Depends on mtfm_pkg. Entries at or above the fill count read as NUL.
module mtfm_buf
   import mtfm_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [7:0]                    wr_data,
   input  logic                          clear,
   output logic                          full,
   output logic [$clog2(MAX_LEN+1)-1:0]  len,
   input  logic [$clog2(MAX_LEN+4)-1:0]  rd_addr,
   output logic [7:0]                    rd_data
);
   localparam int AW = $clog2(MAX_LEN);
   localparam int LW = $clog2(MAX_LEN+1);
   localparam int CW = $clog2(MAX_LEN+4);

   logic [7:0]    mem [MAX_LEN];
   logic [LW-1:0] len_ff;
   logic [LW-1:0] len_in;
   logic [7:0]    rd_data_ff;
   logic          rd_ok_ff;

   assign full = (len_ff == LW'(MAX_LEN));
   assign len  = len_ff;

   // Fill count: grows on a write while not full, drops to zero when the buffer is cleared.
   always_comb begin
      len_in = len_ff;
      if (clear) begin
         len_in = '0;
      end else if (wr_en && !full) begin
         len_in = len_ff + LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   // Write at the fill count; read registered, masked by the fill count.
   always_ff @(posedge clock) begin
      if (wr_en && !full) begin
         mem[len_ff[AW-1:0]] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr[AW-1:0]];
      rd_ok_ff   <= (rd_addr < CW'(len_ff));
   end

   assign rd_data = rd_ok_ff ? rd_data_ff : CH_NUL;

endmodule

// ===== rtl/mtfm_walk.sv =====
// Match sequencer: walks the filter and topic buffers one character a step.
// Depends on mtfm_pkg; reads two mtfm_buf instances through their read ports.
module mtfm_walk
   import mtfm_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          ovf,
   input  logic [$clog2(MAX_LEN+1)-1:0]  f_len,
   input  logic [$clog2(MAX_LEN+1)-1:0]  t_len,
   output logic [$clog2(MAX_LEN+4)-1:0]  f_addr,
   output logic [$clog2(MAX_LEN+4)-1:0]  t_addr,
   input  logic [7:0]                    f_rd,
   input  logic [7:0]                    t_rd,
   output logic                          busy,
   output result_type                    result
);
   localparam int CW = $clog2(MAX_LEN+4);

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_DOLLAR, S_MAIN, S_PLUS_T, S_HASH_T, S_SCAN_F, S_TAIL
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] s_ff, s_in;
   logic [CW-1:0] t_ff, t_in;
   logic [1:0]    ld_ff;
   logic [7:0]    w_ff [4];
   logic [7:0]    tcur_ff;
   logic          done_ff;
   logic [1:0]    status_ff;
   logic          match_ff;

   logic          adv_s, adv_t, fin, fin_m;
   logic [1:0]    fin_st;
   logic [7:0]    fp, f0, f1, f2, f3, t0, t1;
   logic          s_nz;

   // Filter window holds characters s-1 .. s+2; s+3 and t+1 come from memory.
   assign fp   = w_ff[0];
   assign f0   = w_ff[1];
   assign f1   = w_ff[2];
   assign f2   = w_ff[3];
   assign f3   = f_rd;
   assign t0   = tcur_ff;
   assign t1   = t_rd;
   assign s_nz = (s_ff != '0);

   // One step of the matcher: decide the next state and which pointers move.
   always_comb begin
      state_in = state_ff;
      adv_s    = 1'b0;
      adv_t    = 1'b0;
      fin      = 1'b0;
      fin_st   = ST_OK;
      fin_m    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (ovf) begin
                  fin    = 1'b1;
                  fin_st = ST_OVER;
               end else if (f_len == '0 || t_len == '0) begin
                  fin    = 1'b1;
                  fin_st = ST_INVAL;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            if (ld_ff == 2'd2) begin
               state_in = S_DOLLAR;
            end
         end
         S_DOLLAR: begin
            // A leading '$' on one side only never matches.
            if ((f0 == CH_DOLLAR && t0 != CH_DOLLAR) ||
                (t0 == CH_DOLLAR && f0 != CH_DOLLAR)) begin
               fin = 1'b1;
            end else begin
               state_in = S_MAIN;
            end
         end
         S_MAIN: begin
            if (f0 == CH_NUL) begin
               state_in = S_TAIL;
            end else if (is_wild(t0)) begin
               fin    = 1'b1;
               fin_st = ST_INVAL;
            end else if (f0 != t0 || t0 == CH_NUL) begin
               if (f0 == CH_PLUS) begin
                  if ((s_nz && fp != CH_SLASH) || (f1 != CH_NUL && f1 != CH_SLASH)) begin
                     fin    = 1'b1;
                     fin_st = ST_INVAL;
                  end else begin
                     adv_s    = 1'b1;
                     state_in = S_PLUS_T;
                  end
               end else if (f0 == CH_HASH) begin
                  if ((s_nz && fp != CH_SLASH) || f1 != CH_NUL) begin
                     fin    = 1'b1;
                     fin_st = ST_INVAL;
                  end else begin
                     state_in = S_HASH_T;
                  end
               end else if (t0 == CH_NUL && s_nz && fp == CH_PLUS &&
                            f0 == CH_SLASH && f1 == CH_HASH) begin
                  fin   = 1'b1;
                  fin_m = 1'b1;
               end else begin
                  state_in = S_SCAN_F;
               end
            end else begin
               // Characters agree: look ahead for "foo" against "foo/#" and ends.
               if (t1 == CH_NUL && f1 == CH_SLASH && f2 == CH_HASH && f3 == CH_NUL) begin
                  fin   = 1'b1;
                  fin_m = 1'b1;
               end else if (f1 == CH_NUL && t1 == CH_NUL) begin
                  fin   = 1'b1;
                  fin_m = 1'b1;
               end else if (t1 == CH_NUL && f1 == CH_PLUS && f2 == CH_NUL) begin
                  fin = 1'b1;
                  if (f0 != CH_SLASH) begin
                     fin_st = ST_INVAL;
                  end else begin
                     fin_m = 1'b1;
                  end
               end else begin
                  adv_s = 1'b1;
                  adv_t = 1'b1;
               end
            end
         end
         S_PLUS_T: begin
            // Skip one topic level for a '+'.
            if (t0 != CH_NUL && t0 != CH_SLASH) begin
               if (is_wild(t0)) begin
                  fin    = 1'b1;
                  fin_st = ST_INVAL;
               end else begin
                  adv_t = 1'b1;
               end
            end else if (t0 == CH_NUL && f0 == CH_NUL) begin
               fin   = 1'b1;
               fin_m = 1'b1;
            end else begin
               state_in = S_MAIN;
            end
         end
         S_HASH_T: begin
            // A '#' takes the rest of the topic, which must hold no wildcard.
            if (t0 != CH_NUL) begin
               if (is_wild(t0)) begin
                  fin    = 1'b1;
                  fin_st = ST_INVAL;
               end else begin
                  adv_t = 1'b1;
               end
            end else begin
               fin   = 1'b1;
               fin_m = 1'b1;
            end
         end
         S_SCAN_F: begin
            // Mismatch: only check the rest of the filter for a misplaced '#'.
            if (f0 != CH_NUL) begin
               if (f0 == CH_HASH && f1 != CH_NUL) begin
                  fin    = 1'b1;
                  fin_st = ST_INVAL;
               end else begin
                  adv_s = 1'b1;
               end
            end else begin
               fin = 1'b1;
            end
         end
         S_TAIL: begin
            // Filter used up: the remaining topic must hold no wildcard.
            if (t0 != CH_NUL) begin
               if (is_wild(t0)) begin
                  fin    = 1'b1;
                  fin_st = ST_INVAL;
               end else begin
                  adv_t = 1'b1;
               end
            end else begin
               fin = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (fin) begin
         state_in = S_IDLE;
      end
   end

   // Pointer updates and read addresses (from the next pointers when walking).
   always_comb begin
      s_in = adv_s ? (s_ff + CW'(1)) : s_ff;
      t_in = adv_t ? (t_ff + CW'(1)) : t_ff;
      case (state_ff)
         S_IDLE: begin
            s_in   = '0;
            t_in   = '0;
            f_addr = '0;
            t_addr = '0;
         end
         S_LOAD: begin
            f_addr = CW'(ld_ff) + CW'(1);
            t_addr = CW'(1);
         end
         default: begin
            f_addr = s_in + CW'(3);
            t_addr = t_in + CW'(1);
         end
      endcase
   end

   // State, window and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= fin;
      end
      s_ff <= s_in;
      t_ff <= t_in;
      if (fin) begin
         status_ff <= fin_st;
         match_ff  <= fin_m;
      end
      case (state_ff)
         S_IDLE: begin
            ld_ff <= 2'd0;
            for (int i = 0; i < 4; i++) begin
               w_ff[i] <= CH_NUL;
            end
         end
         S_LOAD: begin
            ld_ff <= ld_ff + 2'd1;
            for (int i = 0; i < 3; i++) begin
               w_ff[i] <= w_ff[i+1];
            end
            w_ff[3] <= f_rd;
            if (ld_ff == 2'd0) begin
               tcur_ff <= t_rd;
            end
         end
         default: begin
            if (adv_s) begin
               for (int i = 0; i < 3; i++) begin
                  w_ff[i] <= w_ff[i+1];
               end
               w_ff[3] <= f_rd;
            end
            if (adv_t) begin
               tcur_ff <= t_rd;
            end
         end
      endcase
   end

   assign busy          = (state_ff != S_IDLE) || done_ff;
   assign result.valid  = done_ff;
   assign result.status = status_ff;
   assign result.match  = match_ff;

endmodule

// ===== rtl/mtfm_check.sv =====
// Port-level checks for the topic filter matcher, bound to the top level.
// Depends on mtfm_pkg and on the top level's channel interfaces.
module mtfm_check
   import mtfm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_func,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic       rsp_match
);

   // A match is only ever reported with success status.
   a_match_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_match)
      else $error("match reported with a failing status");

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_match))
      else $error("stalled response word changed");

   // An accepted evaluate word makes the block busy for the next cycle.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FN_EVAL |=> !req_ready)
      else $error("block ready right after an evaluate word");

   // An append word never produces a response in the next cycle.
   a_append_quiet: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && req_ready && req_func != FN_EVAL |=> !rsp_valid)
      else $error("response appeared after an append word");

   // Nothing is presented right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind mqtt_topic_filter_match mtfm_check u_mtfm_check (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_func   (req_ch.func),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_match  (rsp_ch.match)
);

// ===== dv/tb_mqtt_topic_filter_match.sv =====
// Self-checking testbench for the MQTT topic filter matcher.
// It drives request words and checks response words against a predictor.
// Depends on mtfm_pkg, the channel interfaces in mtfm_if.sv and the top level.
`timescale 1ns / 100ps

module tb_mqtt_topic_filter_match;
   import mtfm_pkg::*;

   localparam int MAX_LEN      = 64;
   localparam int RANDOM_WORDS = 900;
   localparam int LONG_HOLD    = 400;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 2 * MAX_LEN + 40;

   // The function code that the block has no use for.
   localparam logic [1:0] FN_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0] status;
      logic       hit;
   } verdict_type;

   // One row of the directed table: a word repeated reps times, with an
   // expected response typed in when typed is set.
   typedef struct packed {
      logic [1:0] fn;
      logic [7:0] ch;
      logic [6:0] reps;
      logic       typed;
      logic [1:0] st;
      logic       hit;
   } step_row_type;

   localparam int N_ROWS = 34;
   localparam step_row_type DIRECTED_ROWS [N_ROWS] = '{
      // Evaluate straight after reset: both buffers are empty.
      '{FN_EVAL,   CH_NUL, 7'd1,  1'b1, ST_INVAL, 1'b0},
      // The unused function code is ignored.
      '{FN_UNUSED, 8'hFF,  7'd1,  1'b0, ST_OK,    1'b0},
      // NUL characters are dropped, so the buffers stay empty.
      '{FN_FILTER, CH_NUL, 7'd1,  1'b0, ST_OK,    1'b0},
      '{FN_TOPIC,  CH_NUL, 7'd1,  1'b0, ST_OK,    1'b0},
      '{FN_EVAL,   CH_NUL, 7'd1,  1'b1, ST_INVAL, 1'b0},
      // Lowest and highest characters.
      '{FN_FILTER, 8'h01,  7'd1,  1'b0, ST_OK,    1'b0},
      '{FN_TOPIC,  8'h01,  7'd1,  1'b0, ST_OK,    1'b0},
      '{FN_EVAL,   8'hFF,  7'd1,  1'b0, ST_OK,    1'b0},
      '{FN_FILTER, 8'hFF,  7'd1,  1'b0, ST_OK,    1'b0},
      '{FN_TOPIC,  8'hFF,  7'd1,  1'b0, ST_OK,    1'b0},
      '{FN_EVAL,   CH_NUL, 7'd1,  1'b0, ST_OK,    1'b0},
      // Multi-level wildcard alone.
      '{FN_FILTER, CH_HASH, 7'd1, 1'b0, ST_OK,    1'b0},
      '{FN_TOPIC,  "a",    7'd1,  1'b0, ST_OK,    1'b0},
      '{FN_EVAL,   CH_NUL, 7'd1,  1'b0, ST_OK,    1'b0},
      // A wildcard never matches a topic that starts with a dollar sign.
      '{FN_FILTER, CH_PLUS, 7'd1, 1'b0, ST_OK,    1'b0},
      '{FN_TOPIC,  CH_DOLLAR, 7'd1, 1'b0, ST_OK,  1'b0},
      '{FN_EVAL,   CH_NUL, 7'd1,  1'b0, ST_OK,    1'b0},
      // A parent topic matches its own multi-level subscription.
      '{FN_FILTER, "a",    7'd1,  1'b0, ST_OK,    1'b0},
      '{FN_FILTER, CH_SLASH, 7'd1, 1'b0, ST_OK,   1'b0},
      '{FN_FILTER, CH_HASH, 7'd1, 1'b0, ST_OK,    1'b0},
      '{FN_TOPIC,  "a",    7'd1,  1'b0, ST_OK,    1'b0},
      '{FN_EVAL,   CH_NUL, 7'd1,  1'b0, ST_OK,    1'b0},
      // A wildcard inside a topic is malformed.
      '{FN_FILTER, "a",    7'd1,  1'b0, ST_OK,    1'b0},
      '{FN_TOPIC,  CH_PLUS, 7'd1, 1'b0, ST_OK,    1'b0},
      '{FN_EVAL,   CH_NUL, 7'd1,  1'b1, ST_INVAL, 1'b0},
      // One character too many in the filter, then in the topic.
      '{FN_FILTER, "a",    7'd65, 1'b0, ST_OK,    1'b0},
      '{FN_TOPIC,  "b",    7'd1,  1'b0, ST_OK,    1'b0},
      '{FN_EVAL,   CH_NUL, 7'd1,  1'b1, ST_OVER,  1'b0},
      '{FN_FILTER, "q",    7'd1,  1'b0, ST_OK,    1'b0},
      '{FN_TOPIC,  "z",    7'd65, 1'b0, ST_OK,    1'b0},
      '{FN_EVAL,   CH_NUL, 7'd1,  1'b1, ST_OVER,  1'b0},
      // Both buffers exactly full.
      '{FN_FILTER, "a",    7'd64, 1'b0, ST_OK,    1'b0},
      '{FN_TOPIC,  "a",    7'd64, 1'b0, ST_OK,    1'b0},
      '{FN_EVAL,   CH_NUL, 7'd1,  1'b0, ST_OK,    1'b0}
   };

   logic clock = 1'b0;
   logic reset;

   // Side information that travels with each request word.
   logic       note_typed;
   logic [1:0] note_status;
   logic       note_hit;

   mtfm_req_if req_ch ();
   mtfm_rsp_if rsp_ch ();

   mqtt_topic_filter_match #(.MAX_LEN(MAX_LEN)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state.
   logic [7:0] flt_mem [MAX_LEN];
   logic [7:0] top_mem [MAX_LEN];
   int         flt_len;
   int         top_len;
   bit         buf_over;

   verdict_type pending_verdicts [$];
   logic [7:0]  flt_chars [$];
   logic [7:0]  top_chars [$];

   int errors;
   int words_counted;
   int verdicts_seen;
   int matches_seen;
   int invalid_seen;
   int overflow_seen;
   int idle_cycles;
   bit steady_phase;
   bit hold_request;

   function automatic logic [7:0] fch(int i);
      return (i < flt_len) ? flt_mem[i] : CH_NUL;
   endfunction

   function automatic logic [7:0] tch(int i);
      return (i < top_len) ? top_mem[i] : CH_NUL;
   endfunction

   function automatic bit is_wildcard(logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_HASH);
   endfunction

   // Walks filter and topic and returns the status; hit tells a match.
   function automatic logic [1:0] judge_topic(output logic hit);
      int s;
      int t;
      hit = 1'b0;
      s = 0;
      t = 0;
      if (flt_len == 0 || top_len == 0) return ST_INVAL;
      if ((fch(0) == CH_DOLLAR && tch(0) != CH_DOLLAR) ||
          (tch(0) == CH_DOLLAR && fch(0) != CH_DOLLAR)) return ST_OK;
      while (fch(s) != CH_NUL) begin
         if (is_wildcard(tch(t))) return ST_INVAL;
         if (fch(s) != tch(t) || tch(t) == CH_NUL) begin
            if (fch(s) == CH_PLUS) begin
               if (s > 0 && fch(s - 1) != CH_SLASH) return ST_INVAL;
               if (fch(s + 1) != CH_NUL && fch(s + 1) != CH_SLASH) return ST_INVAL;
               s++;
               while (tch(t) != CH_NUL && tch(t) != CH_SLASH) begin
                  if (is_wildcard(tch(t))) return ST_INVAL;
                  t++;
               end
               if (tch(t) == CH_NUL && fch(s) == CH_NUL) begin
                  hit = 1'b1;
                  return ST_OK;
               end
            end else if (fch(s) == CH_HASH) begin
               if (s > 0 && fch(s - 1) != CH_SLASH) return ST_INVAL;
               if (fch(s + 1) != CH_NUL) return ST_INVAL;
               while (tch(t) != CH_NUL) begin
                  if (is_wildcard(tch(t))) return ST_INVAL;
                  t++;
               end
               hit = 1'b1;
               return ST_OK;
            end else begin
               if (tch(t) == CH_NUL && s > 0 && fch(s - 1) == CH_PLUS &&
                   fch(s) == CH_SLASH && fch(s + 1) == CH_HASH) begin
                  hit = 1'b1;
                  return ST_OK;
               end
               while (fch(s) != CH_NUL) begin
                  if (fch(s) == CH_HASH && fch(s + 1) != CH_NUL) return ST_INVAL;
                  s++;
               end
               return ST_OK;
            end
         end else begin
            // Topic ends where the filter goes on with a trailing level wildcard.
            if (tch(t + 1) == CH_NUL && fch(s + 1) == CH_SLASH &&
                fch(s + 2) == CH_HASH && fch(s + 3) == CH_NUL) begin
               hit = 1'b1;
               return ST_OK;
            end
            s++;
            t++;
            if (fch(s) == CH_NUL && tch(t) == CH_NUL) begin
               hit = 1'b1;
               return ST_OK;
            end else if (tch(t) == CH_NUL && fch(s) == CH_PLUS && fch(s + 1) == CH_NUL) begin
               if (s > 0 && fch(s - 1) != CH_SLASH) return ST_INVAL;
               hit = 1'b1;
               return ST_OK;
            end
         end
      end
      while (tch(t) != CH_NUL) begin
         if (is_wildcard(tch(t))) return ST_INVAL;
         t++;
      end
      return ST_OK;
   endfunction

   // Applies one accepted request word to the predictor state.
   task automatic absorb_word(logic [1:0] fn, logic [7:0] ch, logic typed,
                              logic [1:0] st, logic hit);
      verdict_type v;
      logic        h;
      case (fn)
         FN_FILTER: begin
            if (ch != CH_NUL) begin
               if (flt_len >= MAX_LEN) buf_over = 1'b1;
               else begin
                  flt_mem[flt_len] = ch;
                  flt_len++;
               end
            end
         end
         FN_TOPIC: begin
            if (ch != CH_NUL) begin
               if (top_len >= MAX_LEN) buf_over = 1'b1;
               else begin
                  top_mem[top_len] = ch;
                  top_len++;
               end
            end
         end
         FN_EVAL: begin
            h = 1'b0;
            if (buf_over) v.status = ST_OVER;
            else v.status = judge_topic(h);
            v.hit = (v.status == ST_OK) ? h : 1'b0;
            if (typed) begin
               v.status = st;
               v.hit = hit;
            end
            pending_verdicts.push_back(v);
            flt_len = 0;
            top_len = 0;
            buf_over = 1'b0;
         end
         default: ;
      endcase
   endtask

   // Watches both channels, predicts, checks and guards against a hang.
   always @(posedge clock) begin
      verdict_type v;
      bit          moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            moved = 1'b1;
            absorb_word(req_ch.func, req_ch.data_byte, note_typed, note_status, note_hit);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            verdicts_seen++;
            if (rsp_ch.match) matches_seen++;
            if (rsp_ch.status == ST_INVAL) invalid_seen++;
            if (rsp_ch.status == ST_OVER) overflow_seen++;
            if (pending_verdicts.size() == 0) begin
               $error("response word with no evaluation pending: status %0d, match %0d",
                      rsp_ch.status, rsp_ch.match);
               errors++;
            end else begin
               v = pending_verdicts.pop_front();
               if (rsp_ch.status !== v.status) begin
                  $error("status mismatch: expected %0d, actual %0d", v.status, rsp_ch.status);
                  errors++;
               end
               if (rsp_ch.match !== v.hit) begin
                  $error("match mismatch: expected %0d, actual %0d", v.hit, rsp_ch.match);
                  errors++;
               end
            end
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no word moved for %0d cycles", IDLE_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   // Response side: random stalls, and one long hold when asked for.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = steady_phase ? 0 : $urandom_range(0, 5);
         if (hold_request) begin
            stall = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Offers one request word after a random gap (none in steady phases) and waits until it is taken.
   task automatic send_word(logic [1:0] fn, logic [7:0] ch, logic typed = 1'b0,
                            logic [1:0] st = ST_OK, logic hit = 1'b0);
      int gap;
      gap = steady_phase ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= fn;
      req_ch.data_byte <= ch;
      note_typed       <= typed;
      note_status      <= st;
      note_hit         <= hit;
      do @(posedge clock); while (!req_ch.ready);
      if (fn != FN_UNUSED && !(fn != FN_EVAL && ch == CH_NUL)) words_counted++;
   endtask

   task automatic add_char(bit to_topic, logic [7:0] c);
      if (to_topic) top_chars.push_back(c);
      else flt_chars.push_back(c);
   endtask

   // Level text from a small alphabet, so that filters often match.
   task automatic push_level(bit to_topic, int code);
      case (code)
         1: add_char(to_topic, "a");
         2: add_char(to_topic, "b");
         3: begin
            add_char(to_topic, "a");
            add_char(to_topic, "b");
         end
         default: ;
      endcase
   endtask

   // Builds one filter and topic pair, mostly well formed, in the char queues.
   task automatic build_case();
      int         kind;
      int         depth;
      int         fdepth;
      int         r;
      int         k;
      int         n;
      bit         dollar;
      bit         tail_hash;
      bit         side;
      int         lv [6];
      logic [7:0] wild;
      flt_chars.delete();
      top_chars.delete();
      kind = $urandom_range(0, 99);
      if (kind < 92) begin
         depth = $urandom_range(1, 4);
         for (k = 0; k < depth; k++) lv[k] = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
         dollar = ($urandom_range(0, 9) == 0);
         if (dollar) add_char(1'b1, CH_DOLLAR);
         for (k = 0; k < depth; k++) begin
            if (k > 0) add_char(1'b1, CH_SLASH);
            push_level(1'b1, lv[k]);
         end
         // Filter follows the topic level by level, with wildcards and changes.
         r = $urandom_range(0, 9);
         fdepth = (r == 0 && depth > 1) ? depth - 1 : (r == 1) ? depth + 1 : depth;
         if (dollar ^ ($urandom_range(0, 7) == 0)) add_char(1'b0, CH_DOLLAR);
         tail_hash = ($urandom_range(0, 5) == 0);
         for (k = 0; k < fdepth; k++) begin
            if (k > 0) add_char(1'b0, CH_SLASH);
            r = $urandom_range(0, 9);
            if (tail_hash && k == fdepth - 1) add_char(1'b0, CH_HASH);
            else if (r < 2) add_char(1'b0, CH_PLUS);
            else if (r < 8 && k < depth) push_level(1'b0, lv[k]);
            else push_level(1'b0, $urandom_range(0, 3));
         end
         if ($urandom_range(0, 7) == 0) begin
            add_char(1'b0, CH_SLASH);
            add_char(1'b0, CH_HASH);
         end
         // Broken pairs: a stray wildcard somewhere in one of them.
         if (kind >= 70) begin
            wild = $urandom_range(0, 1) ? CH_PLUS : CH_HASH;
            if ($urandom_range(0, 1)) top_chars.insert($urandom_range(0, top_chars.size()), wild);
            else flt_chars.insert($urandom_range(0, flt_chars.size()), wild);
         end
      end else if (kind < 95) begin
         // One side left empty.
         side = $urandom_range(0, 1);
         n = $urandom_range(0, 5);
         repeat (n) add_char(side, 8'($urandom_range(1, 255)));
      end else if (kind < 97) begin
         // Around the buffer size, over it now and then.
         side = $urandom_range(0, 1);
         n = $urandom_range(MAX_LEN - 4, MAX_LEN + 4);
         repeat (n) add_char(side, $urandom_range(0, 3) ? 8'("a") : CH_SLASH);
         add_char(!side, "a");
      end else begin
         // Raw noise on both sides.
         n = $urandom_range(0, 8);
         repeat (n) add_char(1'b0, 8'($urandom_range(0, 255)));
         n = $urandom_range(0, 8);
         repeat (n) add_char(1'b1, 8'($urandom_range(0, 255)));
      end
   endtask

   // Sends the queued characters interleaved, with some noise, then evaluates.
   task automatic send_case();
      while (flt_chars.size() + top_chars.size() > 0) begin
         if ($urandom_range(0, 99) < 3) send_word(FN_UNUSED, 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 99) < 2)
            send_word($urandom_range(0, 1) ? FN_TOPIC : FN_FILTER, CH_NUL);
         if (top_chars.size() == 0 || (flt_chars.size() != 0 && $urandom_range(0, 1)))
            send_word(FN_FILTER, flt_chars.pop_front());
         else
            send_word(FN_TOPIC, top_chars.pop_front());
      end
      send_word(FN_EVAL, 8'($urandom_range(0, 255)));
   endtask

   // Main sequence: reset, directed table, random cases, drain and verdict.
   initial begin
      int row;
      int case_no;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.func      <= FN_FILTER;
      req_ch.data_byte <= CH_NUL;
      note_typed       <= 1'b0;
      note_status      <= ST_OK;
      note_hit         <= 1'b0;
      flt_len       = 0;
      top_len       = 0;
      buf_over      = 1'b0;
      errors        = 0;
      words_counted = 0;
      verdicts_seen = 0;
      matches_seen  = 0;
      invalid_seen  = 0;
      overflow_seen = 0;
      idle_cycles   = 0;
      steady_phase  = 1'b0;
      hold_request  = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      for (row = 0; row < N_ROWS; row++) begin
         repeat (DIRECTED_ROWS[row].reps)
            send_word(DIRECTED_ROWS[row].fn, DIRECTED_ROWS[row].ch, DIRECTED_ROWS[row].typed,
                      DIRECTED_ROWS[row].st, DIRECTED_ROWS[row].hit);
      end

      // Random cases, with stretches without gaps, one long response hold
      // and one pause until every response is back.
      words_counted = 0;
      case_no = 0;
      while (words_counted < RANDOM_WORDS) begin
         steady_phase = (case_no % 25) >= 20;
         if (case_no == 15) hold_request = 1'b1;
         if (case_no == 40) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (pending_verdicts.size() != 0) @(posedge clock);
         end
         build_case();
         send_case();
         case_no++;
      end

      // Drain.
      req_ch.valid <= 1'b0;
      steady_phase = 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d counted random words in %0d cases; %0d responses checked.",
               words_counted, case_no, verdicts_seen);
      $display("Responses: %0d matches, %0d invalid, %0d overflow.",
               matches_seen, invalid_seen, overflow_seen);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
